@@ sv/lav_pkg.sv @@
// ----------------------------------------------------------------------------
// lav_pkg
// Shared types, widths, latencies and arithmetic helpers of the look-at view
// matrix pipeline.
// ----------------------------------------------------------------------------
package lav_pkg;

	localparam int MAG_W   = 30;
	localparam int RAD_W   = 2 * MAG_W + 2;
	localparam int ROOT_W  = RAD_W / 2;
	localparam int REM_W   = ROOT_W + 3;
	localparam int QUO_W   = ROOT_W;
	localparam int NORM_LAT = 5 + ROOT_W + QUO_W + 1;

	typedef logic [2:0][31:0] vec32_t;
	typedef logic [2:0][63:0] vec64_t;
	typedef logic [5:0][63:0] terms_t;

	typedef enum logic [1:0] {
		ROW_U = 2'd0,
		ROW_V = 2'd1,
		ROW_W = 2'd2
	} row_t;

	localparam logic signed [63:0] AXIS_MAX = 64'sd1073741824;
	localparam logic signed [63:0] AXIS_MIN = -64'sd1073741824;
	localparam logic signed [63:0] OFF_MAX  = 64'sd4294967295;
	localparam logic signed [63:0] OFF_MIN  = -64'sd4294967296;

	function automatic logic signed [63:0] smul(input logic signed [31:0] a,
		input logic signed [31:0] b);
		logic signed [63:0] ax;
		logic signed [63:0] bx;
		ax = {{32{a[31]}}, a};
		bx = {{32{b[31]}}, b};
		smul = ax * bx;
	endfunction

	// products of a x b, paired so that component i is term 2i minus term 2i+1
	function automatic terms_t cross_terms(input vec32_t a, input vec32_t b);
		terms_t t;
		t[0] = smul(a[1], b[2]);
		t[1] = smul(a[2], b[1]);
		t[2] = smul(a[2], b[0]);
		t[3] = smul(a[0], b[2]);
		t[4] = smul(a[0], b[1]);
		t[5] = smul(a[1], b[0]);
		cross_terms = t;
	endfunction

	// shift right by 30, round half away from zero
	function automatic logic signed [63:0] rsh30(input logic signed [63:0] x);
		logic [63:0] m;
		logic [63:0] r;
		m = x[63] ? (~x + 64'd1) : x;
		r = (m + 64'd536870912) >> 30;
		rsh30 = x[63] ? -$signed(r) : $signed(r);
	endfunction

endpackage

@@ sv/lav_delay.sv @@
// ----------------------------------------------------------------------------
// lav_delay
// Enabled shift line that carries side data and valid bits alongside a unit.
// ----------------------------------------------------------------------------
module lav_delay #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic [WIDTH-1:0] d,
	output logic [WIDTH-1:0] q
);

	logic [WIDTH-1:0] line_q [DEPTH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++) line_q[i] <= '0;
		end else if (en) begin
			line_q[0] <= d;
			for (int i = 1; i < DEPTH; i++) line_q[i] <= line_q[i-1];
		end
	end

	assign q = line_q[DEPTH-1];

endmodule

@@ sv/lav_isqrt.sv @@
// ----------------------------------------------------------------------------
// lav_isqrt
// Pipelined integer square root, one result bit per stage, floor result.
// ----------------------------------------------------------------------------
module lav_isqrt (
	input  logic                        clk,
	input  logic                        en,
	input  logic [lav_pkg::RAD_W-1:0]   radicand,
	output logic [lav_pkg::ROOT_W-1:0]  root
);

	localparam int N = lav_pkg::ROOT_W;

	logic [lav_pkg::ROOT_W-1:0] root_q [N];
	logic [lav_pkg::REM_W-1:0]  rem_q  [N];
	logic [lav_pkg::RAD_W-1:0]  rad_q  [N];
	logic [lav_pkg::ROOT_W-1:0] root_d [N];
	logic [lav_pkg::REM_W-1:0]  rem_d  [N];
	logic [lav_pkg::RAD_W-1:0]  rad_d  [N];

	always_comb begin
		logic [lav_pkg::ROOT_W-1:0] r;
		logic [lav_pkg::REM_W-1:0]  rm;
		logic [lav_pkg::RAD_W-1:0]  x;
		logic [lav_pkg::REM_W-1:0]  sh;
		logic [lav_pkg::REM_W-1:0]  tr;
		for (int k = 0; k < N; k++) begin
			if (k == 0) begin
				r  = '0;
				rm = '0;
				x  = radicand;
			end else begin
				r  = root_q[k-1];
				rm = rem_q[k-1];
				x  = rad_q[k-1];
			end
			sh = {rm[lav_pkg::REM_W-3:0], x[lav_pkg::RAD_W-1 -: 2]};
			tr = {1'b0, r, 2'b01};
			if (sh >= tr) begin
				rem_d[k]  = sh - tr;
				root_d[k] = {r[lav_pkg::ROOT_W-2:0], 1'b1};
			end else begin
				rem_d[k]  = sh;
				root_d[k] = {r[lav_pkg::ROOT_W-2:0], 1'b0};
			end
			rad_d[k] = {x[lav_pkg::RAD_W-3:0], 2'b00};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < N; k++) begin
				root_q[k] <= root_d[k];
				rem_q[k]  <= rem_d[k];
				rad_q[k]  <= rad_d[k];
			end
		end
	end

	assign root = root_q[N-1];

endmodule

@@ sv/lav_div.sv @@
// ----------------------------------------------------------------------------
// lav_div
// Pipelined restoring divider: round(m * 2^30 / s), one quotient bit per stage.
// ----------------------------------------------------------------------------
module lav_div (
	input  logic                       clk,
	input  logic                       en,
	input  logic [lav_pkg::MAG_W-1:0]  mag,
	input  logic [lav_pkg::ROOT_W-1:0] divisor,
	output logic [lav_pkg::QUO_W-1:0]  quo
);

	localparam int N = lav_pkg::QUO_W;
	localparam int W = lav_pkg::ROOT_W;

	logic [W-1:0] rem_q [N];
	logic [W-1:0] low_q [N];
	logic [W-1:0] div_q [N];
	logic [N-1:0] quo_q [N];
	logic [W-1:0] rem_d [N];
	logic [W-1:0] low_d [N];
	logic [N-1:0] quo_d [N];

	always_comb begin
		logic [W-1:0] rm;
		logic [W-1:0] lo;
		logic [W-1:0] dv;
		logic [N-1:0] qq;
		logic [W:0]   sh;
		for (int k = 0; k < N; k++) begin
			if (k == 0) begin
				rm = {2'b00, mag[lav_pkg::MAG_W-1:1]};
				lo = {mag[0], divisor[W-1:1]};
				dv = divisor;
				qq = '0;
			end else begin
				rm = rem_q[k-1];
				lo = low_q[k-1];
				dv = div_q[k-1];
				qq = quo_q[k-1];
			end
			sh = {rm, lo[W-1]};
			if (sh >= {1'b0, dv}) begin
				rem_d[k] = W'(sh - {1'b0, dv});
				quo_d[k] = {qq[N-2:0], 1'b1};
			end else begin
				rem_d[k] = W'(sh);
				quo_d[k] = {qq[N-2:0], 1'b0};
			end
			low_d[k] = {lo[W-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q[0] <= rem_d[0];
			low_q[0] <= low_d[0];
			quo_q[0] <= quo_d[0];
			div_q[0] <= divisor;
			for (int k = 1; k < N; k++) begin
				rem_q[k] <= rem_d[k];
				low_q[k] <= low_d[k];
				quo_q[k] <= quo_d[k];
				div_q[k] <= div_q[k-1];
			end
		end
	end

	assign quo = quo_q[N-1];

endmodule

@@ sv/lav_norm.sv @@
// ----------------------------------------------------------------------------
// lav_norm
// Pipelined 3-vector normalizer: scale to [2^29, 2^30), square root of the
// sum of squares, per-component divide; Q2.30 result and a zero flag.
// ----------------------------------------------------------------------------
module lav_norm (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  lav_pkg::vec64_t vec,
	output lav_pkg::vec32_t unit,
	output logic            zero
);

	localparam int MW      = lav_pkg::MAG_W;
	localparam int MSB_POS = MW - 1;

	typedef struct packed {
		logic [2:0][MW-1:0] mn;
		logic [2:0]         neg;
		logic               zero;
	} root_side_t;

	typedef struct packed {
		logic [2:0] neg;
		logic       zero;
	} quo_side_t;

	lav_pkg::vec64_t      mag_c;
	lav_pkg::vec64_t      mag_s1, mag_s2;
	logic [63:0]          mx_s1;
	logic [2:0]           neg_s1, neg_s2, neg_s3, neg_s4, neg_s5;
	logic [5:0]           p_c, p_s2;
	logic                 zero_s2, zero_s3, zero_s4, zero_s5;
	logic [2:0][MW-1:0]   mn_c, mn_s3, mn_s4, mn_s5;
	logic [2:0][2*MW-1:0] sq_s4;
	logic [lav_pkg::RAD_W-1:0]  sum_s5;
	logic [lav_pkg::ROOT_W-1:0] root;
	root_side_t           rs_in, rs_out;
	quo_side_t            qs_in, qs_out;
	logic [2:0][lav_pkg::QUO_W-1:0] quo;
	lav_pkg::vec32_t      unit_s6;
	logic                 zero_s6;

	always_comb begin
		for (int i = 0; i < 3; i++) mag_c[i] = vec[i][63] ? (~vec[i] + 64'd1) : vec[i];
	end

	always_comb begin
		p_c = '0;
		for (int b = 0; b < 64; b++) begin
			if (mx_s1[b]) p_c = 6'(b);
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (p_s2 >= 6'(MSB_POS)) mn_c[i] = MW'(mag_s2[i] >> (p_s2 - 6'(MSB_POS)));
			else mn_c[i] = MW'(mag_s2[i] << (6'(MSB_POS) - p_s2));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				neg_s1[i] <= vec[i][63];
				sq_s4[i]  <= (2*MW)'(mn_s3[i]) * (2*MW)'(mn_s3[i]);
			end
			mag_s1  <= mag_c;
			mx_s1   <= mag_c[0] | mag_c[1] | mag_c[2];
			mag_s2  <= mag_s1;
			neg_s2  <= neg_s1;
			p_s2    <= p_c;
			zero_s2 <= (mx_s1 == 64'd0);
			mn_s3   <= mn_c;
			neg_s3  <= neg_s2;
			zero_s3 <= zero_s2;
			mn_s4   <= mn_s3;
			neg_s4  <= neg_s3;
			zero_s4 <= zero_s3;
			sum_s5  <= lav_pkg::RAD_W'(sq_s4[0]) + lav_pkg::RAD_W'(sq_s4[1])
				+ lav_pkg::RAD_W'(sq_s4[2]);
			mn_s5   <= mn_s4;
			neg_s5  <= neg_s4;
			zero_s5 <= zero_s4;
		end
	end

	lav_isqrt u_isqrt (
		.clk      (clk),
		.en       (en),
		.radicand (sum_s5),
		.root     (root)
	);

	assign rs_in = '{mn: mn_s5, neg: neg_s5, zero: zero_s5};

	lav_delay #(.WIDTH($bits(root_side_t)), .DEPTH(lav_pkg::ROOT_W)) u_root_side (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.d      (rs_in),
		.q      (rs_out)
	);

	for (genvar i = 0; i < 3; i++) begin : g_lane
		lav_div u_div (
			.clk     (clk),
			.en      (en),
			.mag     (rs_out.mn[i]),
			.divisor (root),
			.quo     (quo[i])
		);
	end

	assign qs_in = '{neg: rs_out.neg, zero: rs_out.zero};

	lav_delay #(.WIDTH($bits(quo_side_t)), .DEPTH(lav_pkg::QUO_W)) u_quo_side (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.d      (qs_in),
		.q      (qs_out)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				unit_s6[i] <= qs_out.neg[i] ? -(32'(quo[i])) : 32'(quo[i]);
			end
			zero_s6 <= qs_out.zero;
		end
	end

	assign unit = unit_s6;
	assign zero = zero_s6;

endmodule

@@ sv/look_at_view_matrix.sv @@
// ----------------------------------------------------------------------------
// look_at_view_matrix
// Camera basis from position, aim and up: rows u, v, w in Q2.30 with offsets.
//
//  channel  signals                                      dir  per request
//  cfg      cfg_wr_en, cfg_wr_data                       in   aim_is_target
//  in       in_valid, in_stall, pos_*, aim_*, up_*       in   one camera
//  out      out_valid, out_stall, row_index, axis_*, ... out  three rows
//
// Most of the path from an accepted request to its first row lies in two
// normalizers of 68 stages each (square root and divider, one bit per stage).
// A request may enter every cycle while in_stall is low; rows leave one per
// cycle while out_stall is low, and each request yields three rows.
// The whole pipeline advances together and holds while the output register
// still has rows to deliver. Reset empties the pipeline and clears the mode.
// ----------------------------------------------------------------------------
module look_at_view_matrix (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic               cfg_wr_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] pos_z,
	input  logic signed [31:0] aim_x,
	input  logic signed [31:0] aim_y,
	input  logic signed [31:0] aim_z,
	input  logic signed [31:0] up_x,
	input  logic signed [31:0] up_y,
	input  logic signed [31:0] up_z,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         row_index,
	output logic signed [31:0] axis_x,
	output logic signed [31:0] axis_y,
	output logic signed [31:0] axis_z,
	output logic signed [32:0] offset,
	output logic               last_row,
	output logic               degenerate
);

	typedef struct packed {
		logic            vld;
		lav_pkg::vec32_t pos;
		lav_pkg::vec32_t up;
	} side_a_t;

	typedef struct packed {
		logic            vld;
		logic            zw;
		lav_pkg::vec32_t w;
		lav_pkg::vec32_t pos;
	} side_b_t;

	logic               aim_is_target_q;
	lav_pkg::row_t      row_q;
	logic               en;

	lav_pkg::vec32_t    pos_c;
	logic [2:0][32:0]   aim_c;

	logic               valid_s1;
	lav_pkg::vec32_t    pos_s1, up_s1;
	logic [2:0][32:0]   aim_s1;
	lav_pkg::vec64_t    aim_ext;

	lav_pkg::vec32_t    w_n1, u_n2;
	logic               zw_n1, zu_n2;
	side_a_t            sa_in, sa_out;
	side_b_t            sb_in, sb_out;

	logic               valid_s2, valid_s3, valid_s4, valid_s5, valid_s6;
	logic               valid_s7, valid_s8, valid_s9;
	lav_pkg::terms_t    prod_s2, prod_s4;
	lav_pkg::vec32_t    w_s2, pos_s2, w_s3, pos_s3;
	logic               zw_s2, zw_s3;
	lav_pkg::vec64_t    cr_s3, cr_s5;
	lav_pkg::vec32_t    w_s4, u_s4, pos_s4, w_s5, u_s5, pos_s5, w_s6, u_s6, pos_s6;
	lav_pkg::vec32_t    v_s6, v_c;
	logic               degen_s4, degen_s5, degen_s6, degen_s7, degen_s8, degen_s9;
	logic [2:0][2:0][31:0] axes_c, axes_s7, axes_s8, axes_s9;
	logic [2:0][2:0][63:0] dprod_s7;
	lav_pkg::vec64_t    dot_s8;
	logic [2:0][32:0]   off_c, off_s9;

	assign en       = !valid_s9 || (!out_stall && row_q == lav_pkg::ROW_W);
	assign in_stall = !en;

	assign pos_c = {pos_z, pos_y, pos_x};

	always_comb begin
		logic [2:0][31:0] aim_v;
		aim_v = {aim_z, aim_y, aim_x};
		for (int i = 0; i < 3; i++) begin
			if (aim_is_target_q)
				aim_c[i] = {aim_v[i][31], aim_v[i]} - {pos_c[i][31], pos_c[i]};
			else
				aim_c[i] = {aim_v[i][31], aim_v[i]};
			aim_ext[i] = {{31{aim_s1[i][32]}}, aim_s1[i]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			aim_is_target_q <= 1'b0;
			row_q           <= lav_pkg::ROW_U;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
			valid_s8 <= 1'b0;
			valid_s9 <= 1'b0;
		end else begin
			if (cfg_wr_en) aim_is_target_q <= cfg_wr_data;
			if (valid_s9 && !out_stall) begin
				case (row_q)
					lav_pkg::ROW_U: row_q <= lav_pkg::ROW_V;
					lav_pkg::ROW_V: row_q <= lav_pkg::ROW_W;
					default:        row_q <= lav_pkg::ROW_U;
				endcase
			end
			if (en) begin
				valid_s1 <= in_valid;
				valid_s2 <= sa_out.vld;
				valid_s3 <= valid_s2;
				valid_s4 <= sb_out.vld;
				valid_s5 <= valid_s4;
				valid_s6 <= valid_s5;
				valid_s7 <= valid_s6;
				valid_s8 <= valid_s7;
				valid_s9 <= valid_s8;
			end
		end
	end

	lav_norm u_norm_w (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.vec    (aim_ext),
		.unit   (w_n1),
		.zero   (zw_n1)
	);

	assign sa_in = '{vld: valid_s1, pos: pos_s1, up: up_s1};

	lav_delay #(.WIDTH($bits(side_a_t)), .DEPTH(lav_pkg::NORM_LAT)) u_side_a (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.d      (sa_in),
		.q      (sa_out)
	);

	lav_norm u_norm_u (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.vec    (cr_s3),
		.unit   (u_n2),
		.zero   (zu_n2)
	);

	assign sb_in = '{vld: valid_s3, zw: zw_s3, w: w_s3, pos: pos_s3};

	lav_delay #(.WIDTH($bits(side_b_t)), .DEPTH(lav_pkg::NORM_LAT)) u_side_b (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.d      (sb_in),
		.q      (sb_out)
	);

	always_comb begin
		logic signed [63:0] t;
		logic signed [63:0] o;
		for (int i = 0; i < 3; i++) begin
			t = lav_pkg::rsh30(cr_s5[i]);
			if (t > lav_pkg::AXIS_MAX) t = lav_pkg::AXIS_MAX;
			else if (t < lav_pkg::AXIS_MIN) t = lav_pkg::AXIS_MIN;
			v_c[i] = t[31:0];
		end
		axes_c[lav_pkg::ROW_U] = degen_s6 ? '0 : u_s6;
		axes_c[lav_pkg::ROW_V] = degen_s6 ? '0 : v_s6;
		axes_c[lav_pkg::ROW_W] = degen_s6 ? '0 : w_s6;
		for (int r = 0; r < 3; r++) begin
			o = -lav_pkg::rsh30(dot_s8[r]);
			if (o > lav_pkg::OFF_MAX) o = lav_pkg::OFF_MAX;
			else if (o < lav_pkg::OFF_MIN) o = lav_pkg::OFF_MIN;
			off_c[r] = degen_s8 ? '0 : o[32:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pos_s1  <= pos_c;
			up_s1   <= {up_z, up_y, up_x};
			aim_s1  <= aim_c;

			prod_s2 <= lav_pkg::cross_terms(w_n1, sa_out.up);
			w_s2    <= w_n1;
			zw_s2   <= zw_n1;
			pos_s2  <= sa_out.pos;

			for (int i = 0; i < 3; i++) cr_s3[i] <= prod_s2[2*i] - prod_s2[2*i+1];
			w_s3    <= w_s2;
			zw_s3   <= zw_s2;
			pos_s3  <= pos_s2;

			prod_s4  <= lav_pkg::cross_terms(sb_out.w, u_n2);
			w_s4     <= sb_out.w;
			u_s4     <= u_n2;
			pos_s4   <= sb_out.pos;
			degen_s4 <= sb_out.zw || zu_n2;

			for (int i = 0; i < 3; i++) cr_s5[i] <= prod_s4[2*i] - prod_s4[2*i+1];
			w_s5     <= w_s4;
			u_s5     <= u_s4;
			pos_s5   <= pos_s4;
			degen_s5 <= degen_s4;

			v_s6     <= v_c;
			w_s6     <= w_s5;
			u_s6     <= u_s5;
			pos_s6   <= pos_s5;
			degen_s6 <= degen_s5;

			for (int r = 0; r < 3; r++) begin
				for (int i = 0; i < 3; i++) dprod_s7[r][i] <= lav_pkg::smul(axes_c[r][i], pos_s6[i]);
			end
			axes_s7  <= axes_c;
			degen_s7 <= degen_s6;

			for (int r = 0; r < 3; r++) dot_s8[r] <= dprod_s7[r][0] + dprod_s7[r][1] + dprod_s7[r][2];
			axes_s8  <= axes_s7;
			degen_s8 <= degen_s7;

			off_s9   <= off_c;
			axes_s9  <= axes_s8;
			degen_s9 <= degen_s8;
		end
	end

	always_comb begin
		case (row_q)
			lav_pkg::ROW_U: begin
				axis_x = axes_s9[0][0];
				axis_y = axes_s9[0][1];
				axis_z = axes_s9[0][2];
				offset = off_s9[0];
			end
			lav_pkg::ROW_V: begin
				axis_x = axes_s9[1][0];
				axis_y = axes_s9[1][1];
				axis_z = axes_s9[1][2];
				offset = off_s9[1];
			end
			default: begin
				axis_x = axes_s9[2][0];
				axis_y = axes_s9[2][1];
				axis_z = axes_s9[2][2];
				offset = off_s9[2];
			end
		endcase
	end

	assign out_valid  = valid_s9;
	assign row_index  = row_q;
	assign last_row   = (row_q == lav_pkg::ROW_W);
	assign degenerate = degen_s9;

	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && degenerate |-> axis_x == 0 && axis_y == 0 && axis_z == 0 && offset == 0)
		else $error("degenerate row carries nonzero data");

	a_row_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && last_row |=> row_index == lav_pkg::ROW_U)
		else $error("row index did not wrap after last row");

	a_rows_follow: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last_row |=> out_valid && $stable(degenerate))
		else $error("row run broken before last row");

	a_axis_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> axis_x >= -32'sd1073741824 && axis_x <= 32'sd1073741824 &&
			axis_y >= -32'sd1073741824 && axis_y <= 32'sd1073741824)
		else $error("axis component out of unit range");

endmodule

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench of the look-at view matrix pipeline. A predictor
// computes the u, v, w rows of each camera request. The rows that the block
// returns are compared with them in order, field by field, across both aim
// modes and under random idle cycles and a long output stall.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic signed [31:0] px, py, pz, ax, ay, az, ux, uy, uz;
	} camera_t;

	typedef struct packed {
		lav_pkg::row_t      row;
		logic signed [31:0] x, y, z;
		logic signed [32:0] off;
		logic               last;
		logic               degen;
	} row_rec_t;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_wr_en = 0;
	logic cfg_wr_data = 0;
	logic in_valid = 0;
	logic in_stall;
	logic signed [31:0] pos_x = 0, pos_y = 0, pos_z = 0;
	logic signed [31:0] aim_x = 0, aim_y = 0, aim_z = 0;
	logic signed [31:0] up_x = 0, up_y = 0, up_z = 0;
	logic out_valid;
	logic out_stall = 0;
	logic [1:0] row_index;
	logic signed [31:0] axis_x, axis_y, axis_z;
	logic signed [32:0] offset;
	logic last_row, degenerate;

	look_at_view_matrix dut (.*);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	camera_t  pending_q[$];
	row_rec_t rows_q[$];
	logic     aim_mode = 0;
	int       mismatches = 0;
	int       idle_cycles = 0;
	int       hold_off = 0;

	function automatic logic [63:0] magn(input logic signed [63:0] x);
		return x < 0 ? -x : x;
	endfunction

	function automatic logic signed [63:0] round30(input logic signed [63:0] x);
		logic [63:0] m;
		m = (magn(x) + 64'd536870912) >> 30;
		return x < 0 ? -$signed(m) : $signed(m);
	endfunction

	function automatic logic [63:0] int_sqrt(input logic [63:0] x);
		logic [63:0] r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > x) b = b >> 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x = x - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic bit unit_vec(input logic signed [63:0] v[3],
		output logic signed [63:0] u[3]);
		logic [63:0] m[3];
		logic [63:0] mx, sum, s, q;
		mx = 0;
		sum = 0;
		for (int i = 0; i < 3; i++) begin
			m[i] = magn(v[i]);
			if (m[i] > mx) mx = m[i];
		end
		if (mx == 0) return 0;
		while (mx >= (64'd1 << 30)) begin
			for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
			mx = mx >> 1;
		end
		while (mx < (64'd1 << 29)) begin
			for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
			mx = mx << 1;
		end
		for (int i = 0; i < 3; i++) sum = sum + m[i] * m[i];
		s = int_sqrt(sum);
		for (int i = 0; i < 3; i++) begin
			q = ((m[i] << 30) + (s >> 1)) / s;
			u[i] = v[i] < 0 ? -$signed(q) : $signed(q);
		end
		return 1;
	endfunction

	function automatic void cross_vec(input logic signed [63:0] a[3],
		input logic signed [63:0] b[3], output logic signed [63:0] r[3]);
		r[0] = a[1] * b[2] - a[2] * b[1];
		r[1] = a[2] * b[0] - a[0] * b[2];
		r[2] = a[0] * b[1] - a[1] * b[0];
	endfunction

	task automatic predict_rows(input camera_t c, input logic tgt);
		logic signed [63:0] p[3], a[3], up[3], cr[3];
		logic signed [63:0] ax[3][3];
		logic signed [63:0] dot, off, t;
		bit degen;
		row_rec_t r;
		p = '{c.px, c.py, c.pz};
		a = '{c.ax, c.ay, c.az};
		up = '{c.ux, c.uy, c.uz};
		ax = '{default: 0};
		if (tgt)
			for (int i = 0; i < 3; i++) a[i] = a[i] - p[i];
		degen = !unit_vec(a, ax[2]);
		if (!degen) begin
			cross_vec(ax[2], up, cr);
			degen = !unit_vec(cr, ax[0]);
			if (!degen) begin
				cross_vec(ax[2], ax[0], cr);
				for (int i = 0; i < 3; i++) begin
					t = round30(cr[i]);
					ax[1][i] = t > lav_pkg::AXIS_MAX ? lav_pkg::AXIS_MAX :
						(t < lav_pkg::AXIS_MIN ? lav_pkg::AXIS_MIN : t);
				end
			end
		end
		for (int k = 0; k < 3; k++) begin
			dot = 0;
			off = 0;
			if (degen)
				for (int i = 0; i < 3; i++) ax[k][i] = 0;
			for (int i = 0; i < 3; i++) dot = dot + ax[k][i] * p[i];
			if (!degen) begin
				off = -round30(dot);
				off = off > lav_pkg::OFF_MAX ? lav_pkg::OFF_MAX :
					(off < lav_pkg::OFF_MIN ? lav_pkg::OFF_MIN : off);
			end
			r.row = lav_pkg::row_t'(k);
			r.x = ax[k][0][31:0];
			r.y = ax[k][1][31:0];
			r.z = ax[k][2][31:0];
			r.off = off[32:0];
			r.last = (k == 2);
			r.degen = degen;
			rows_q.push_back(r);
		end
	endtask

	function automatic logic signed [31:0] rnd_field();
		case ($urandom_range(0, 9))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2: return 0;
			3: return $signed($urandom_range(0, 16)) - 8;
			4, 5: return $signed($urandom_range(0, 32'h000fffff)) - 32'sh00080000;
			default: return $urandom;
		endcase
	endfunction

	function automatic camera_t rnd_camera();
		camera_t c;
		int k;
		c = '{rnd_field(), rnd_field(), rnd_field(), rnd_field(), rnd_field(),
			rnd_field(), rnd_field(), rnd_field(), rnd_field()};
		k = $urandom_range(0, 15);
		if (k == 0) begin
			c.ux = c.ax * 2;
			c.uy = c.ay * 2;
			c.uz = c.az * 2;
		end else if (k == 1) begin
			c.ux = 0;
			c.uy = 0;
			c.uz = 0;
		end else if (k == 2) begin
			c.ax = 0;
			c.ay = 0;
			c.az = 0;
		end else if (k == 3) begin
			c.ax = c.px;
			c.ay = c.py;
			c.az = c.pz;
		end
		return c;
	endfunction

	int gap = 0;
	always @(posedge clk) begin
		if (in_valid && !in_stall) begin
			predict_rows({pos_x, pos_y, pos_z, aim_x, aim_y, aim_z, up_x, up_y, up_z},
				aim_mode);
		end
		if (arst_n && (!in_valid || !in_stall)) begin
			if (gap > 0) begin
				gap <= gap - 1;
				in_valid <= 0;
			end else if (pending_q.size() > 0) begin
				{pos_x, pos_y, pos_z, aim_x, aim_y, aim_z, up_x, up_y, up_z}
					<= pending_q.pop_front();
				in_valid <= 1;
				gap <= $urandom_range(0, 1) ? 0 : $urandom_range(0, 4);
			end else begin
				in_valid <= 0;
			end
		end
	end

	int wait_n = 0;
	always @(posedge clk) begin
		if (out_valid && !out_stall) begin
			row_rec_t e, got;
			got = '{lav_pkg::row_t'(row_index), axis_x, axis_y, axis_z, offset, last_row,
				degenerate};
			if (rows_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected row %p", got);
			end else begin
				e = rows_q.pop_front();
				if (got !== e) begin
					mismatches++;
					if (mismatches <= 10) $display("mismatch exp %p got %p", e, got);
				end
			end
		end
		if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			out_stall <= 1;
		end else if (wait_n > 0) begin
			wait_n <= wait_n - 1;
			out_stall <= 1;
		end else begin
			out_stall <= 0;
			if (out_valid && !out_stall)
				wait_n <= $urandom_range(0, 2) ? 0 : $urandom_range(0, 4);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 2000) begin
			$display("look_at_view_matrix regression: fail");
			$finish;
		end
	end

	task automatic drain();
		while (pending_q.size() > 0 || in_valid || rows_q.size() > 0) @(posedge clk);
		repeat (160) @(posedge clk);
	endtask

	task automatic set_mode(input logic m);
		@(posedge clk);
		cfg_wr_en <= 1;
		cfg_wr_data <= m;
		@(posedge clk);
		cfg_wr_en <= 0;
		aim_mode = m;
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		pending_q.push_back('{0, 0, 0, 0, 0, 32'h10000, 0, 32'h10000, 0});
		pending_q.push_back('{0, 0, 0, 0, 0, 0, 0, 32'h10000, 0});
		pending_q.push_back('{0, 0, 0, 0, 0, 32'h10000, 0, 0, 32'h10000});
		pending_q.push_back('{0, 0, 0, 0, 0, 32'h10000, 0, 0, 0});
		pending_q.push_back('{32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh80000000,
			32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000});
		pending_q.push_back('{32'sh80000000, 32'sh80000000, 32'sh80000000, 1, -1, 1,
			32'sh80000000, 32'sh7fffffff, 0});
		pending_q.push_back('{-1, -1, -1, -1, 2, 3, 5, -7, 1});
		pending_q.push_back('{32'h12345, 32'h6789, -32'h4321, 32'h10000, 32'h10000,
			32'h10000, 32'h10000, 32'h10000, 32'h10000});
		for (int i = 0; i < 8; i++) pending_q.push_back(rnd_camera());
		drain();
		set_mode(1);
		pending_q.push_back('{5, 6, 7, 5, 6, 7, 0, 1, 0});
		pending_q.push_back('{32'sh7fffffff, 0, 0, 32'sh80000000, 0, 0, 0, 32'h10000, 0});
		pending_q.push_back('{32'sh80000000, 32'sh80000000, 0, 32'sh7fffffff,
			32'sh7fffffff, 1, 0, 0, 32'h10000});
		for (int i = 0; i < 120; i++) pending_q.push_back(rnd_camera());
		hold_off <= 400;
		drain();
		set_mode(0);
		for (int i = 0; i < 120; i++) pending_q.push_back(rnd_camera());
		drain();
		set_mode(1);
		for (int i = 0; i < 100; i++) pending_q.push_back(rnd_camera());
		drain();
		if (mismatches == 0)
			$display("look_at_view_matrix regression: pass");
		else
			$display("look_at_view_matrix regression: fail");
		$finish;
	end
endmodule

@@ filelist.f @@
sv/lav_pkg.sv
sv/lav_delay.sv
sv/lav_isqrt.sv
sv/lav_div.sv
sv/lav_norm.sv
sv/look_at_view_matrix.sv
tb/tb.sv
